// File: src/imd_disk_image_parser_top_macros.svh
`ifndef IMD_DISK_IMAGE_PARSER_TOP_MACROS_SVH
`define IMD_DISK_IMAGE_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define IMD_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/imd_pkg.sv
`timescale 1ns / 1ps

package imd_pkg;

   typedef enum logic [1:0] {
      KIND_SECTOR = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_FILL   = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_BAD_MODE      = 2'd0,
      ERR_BAD_SIZE      = 2'd1,
      ERR_BAD_STATUS    = 2'd2,
      ERR_SIZE_MISMATCH = 2'd3
   } error_type;

   // reported sector status
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_MISSING = 2'd1;
   localparam logic [1:0] STAT_DELETED = 2'd2;
   localparam logic [1:0] STAT_BAD_CRC = 2'd3;

   // raw status byte codes
   localparam logic [7:0] RAW_MISSING     = 8'd0;
   localparam logic [7:0] RAW_OK_FILL     = 8'd2;
   localparam logic [7:0] RAW_DELETED_END = 8'd4;

   localparam logic [7:0] COMMENT_END = 8'h1A;
   localparam logic [7:0] MODE_MAX    = 8'd5;
   localparam logic [7:0] SIZE_MAX    = 8'd6;
   localparam logic [7:0] STATUS_MAX  = 8'd8;

   localparam int unsigned CYL_MAP_BIT  = 7;
   localparam int unsigned HEAD_MAP_BIT = 6;

   localparam logic [8:0] RATE_HIGH = 9'd500;
   localparam logic [8:0] RATE_MID  = 9'd300;
   localparam logic [8:0] RATE_LOW  = 9'd250;

   localparam logic [13:0] SECTOR_BASE = 14'd128;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] cylinder;
      logic [5:0] head;
      logic [7:0] logical_cylinder;
      logic [7:0] logical_head;
      logic [7:0] sector_id;
      logic [1:0] sector_status;
      logic [2:0] size_code;
      logic [8:0] rate_kbps;
      logic       is_fm;
      logic [7:0] value;
      error_type  error_code;
   } rsp_payload_type;

endpackage

// File: src/imd_req_if.sv
`timescale 1ns / 1ps

interface imd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// File: src/imd_rsp_if.sv
`timescale 1ns / 1ps

interface imd_rsp_if import imd_pkg::*;;
   logic       valid;
   logic       ready;
   kind_type   kind;
   logic [7:0] cylinder;
   logic [5:0] head;
   logic [7:0] logical_cylinder;
   logic [7:0] logical_head;
   logic [7:0] sector_id;
   logic [1:0] sector_status;
   logic [2:0] size_code;
   logic [8:0] rate_kbps;
   logic       is_fm;
   logic [7:0] value;
   error_type  error_code;

   modport source (output valid, output kind, output cylinder, output head,
                   output logical_cylinder, output logical_head, output sector_id,
                   output sector_status, output size_code, output rate_kbps,
                   output is_fm, output value, output error_code, input ready);
   modport sink (input valid, input kind, input cylinder, input head,
                 input logical_cylinder, input logical_head, input sector_id,
                 input sector_status, input size_code, input rate_kbps,
                 input is_fm, input value, input error_code, output ready);
endinterface

// File: src/imd_disk_image_parser_top.sv
// results are registered in the rsp output register, or in the skid entry if it is held
// throughput: one byte per cycle; a two-entry output buffer (register plus skid) lets
//    bytes keep flowing while one result waits, ready drops only when both are full
// map reads come from registered memory ports addressed by the next sector index
// reset (synchronous): back to comment skipping, all codes, counters and flags cleared;
//    the three maps are not cleared and hold whatever was last written
`timescale 1ns / 1ps
`include "imd_disk_image_parser_top_macros.svh"

module imd_disk_image_parser_top import imd_pkg::*; #(
   parameter int MAX_SECTORS = 256
) (
   input logic      clock,
   input logic      reset,
   imd_req_if.sink  req_if,
   imd_rsp_if.source rsp_if
);

   localparam int IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

   typedef enum logic [3:0] {
      PH_COMMENT,
      PH_MODE,
      PH_CYL,
      PH_HEAD,
      PH_COUNT,
      PH_SIZE,
      PH_NUMMAP,
      PH_CYLMAP,
      PH_HEADMAP,
      PH_STATUS,
      PH_DATA,
      PH_FILL,
      PH_HALTED
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [2:0]      mode_ff, mode_in;
   logic [7:0]      cyl_ff, cyl_in;
   logic [7:0]      flags_ff, flags_in;
   logic [7:0]      count_ff, count_in;
   logic [2:0]      size_ff, size_in;
   logic [2:0]      first_size_ff, first_size_in;
   logic            first_seen_ff, first_seen_in;
   logic [7:0]      idx_ff, idx_in;
   logic [12:0]     bcnt_ff, bcnt_in;
   logic            base_zero_ff, base_zero_in;
   logic [1:0]      status_ff, status_in;

   rsp_payload_type head_ff, skid_ff, res;
   logic            head_valid_ff, skid_valid_ff;

   logic [7:0]      num_mem [MAX_SECTORS];
   logic [7:0]      cyl_mem [MAX_SECTORS];
   logic [7:0]      hd_mem [MAX_SECTORS];
   logic [7:0]      num_rd_ff, cyl_rd_ff, hd_rd_ff;

   logic            accept, push, pop;
   logic [7:0]      b;
   logic            num_we, cyl_we, hd_we;
   logic [7:0]      num_wdata;
   logic            idx_in_range, wr_in_range;
   logic [7:0]      idx_next;
   logic            do_maps_done;
   logic            bz_now;

   assign b      = req_if.data_byte;
   assign accept = req_if.valid && req_if.ready;
   assign pop    = head_valid_ff && rsp_if.ready;
   assign req_if.ready = !skid_valid_ff;

   assign idx_in_range = {1'b0, idx_ff} < 9'(MAX_SECTORS);
   assign idx_next     = idx_ff + 8'd1;
   assign bz_now       = base_zero_ff || (b == 8'd0);
   assign num_wdata    = bz_now ? (b + 8'd1) : b;

   function automatic logic [8:0] rate_of(input logic [2:0] mode);
      logic [8:0] r;
      case (mode)
         3'd0, 3'd3: r = RATE_HIGH;
         3'd1, 3'd4: r = RATE_MID;
         default:    r = RATE_LOW;
      endcase
      return r;
   endfunction

   function automatic rsp_payload_type make_error(input error_type code);
      rsp_payload_type p;
      p            = '0;
      p.kind       = KIND_ERROR;
      p.error_code = code;
      return p;
   endfunction

   // descriptor fields of the current sector
   function automatic rsp_payload_type make_sector(
      input kind_type k, input logic [7:0] v, input logic [1:0] st,
      input logic [7:0] cyl, input logic [7:0] flags, input logic [2:0] size,
      input logic [2:0] mode, input logic in_range, input logic [7:0] num_rd,
      input logic [7:0] cyl_rd, input logic [7:0] hd_rd);
      rsp_payload_type p;
      p                  = '0;
      p.kind             = k;
      p.cylinder         = cyl;
      p.head             = flags[5:0];
      p.logical_cylinder = flags[CYL_MAP_BIT] ? (in_range ? cyl_rd : 8'd0) : cyl;
      p.logical_head     = flags[HEAD_MAP_BIT] ? (in_range ? hd_rd : 8'd0)
                                               : {2'b00, flags[5:0]};
      p.sector_id        = in_range ? num_rd : 8'd0;
      p.sector_status    = st;
      p.size_code        = size;
      p.rate_kbps        = rate_of(mode);
      p.is_fm            = (mode < 3'd3);
      p.value            = v;
      p.error_code       = ERR_BAD_MODE;
      return p;
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      cyl_in        = cyl_ff;
      flags_in      = flags_ff;
      count_in      = count_ff;
      size_in       = size_ff;
      first_size_in = first_size_ff;
      first_seen_in = first_seen_ff;
      idx_in        = idx_ff;
      bcnt_in       = bcnt_ff;
      base_zero_in  = base_zero_ff;
      status_in     = status_ff;
      push          = 1'b0;
      res           = '0;
      num_we        = 1'b0;
      cyl_we        = 1'b0;
      hd_we         = 1'b0;
      do_maps_done  = 1'b0;
      if (accept) begin
         case (phase_ff)
            PH_COMMENT: begin
               if (b == COMMENT_END) phase_in = PH_MODE;
            end
            PH_MODE: begin
               if (b > MODE_MAX) begin
                  push     = 1'b1;
                  res      = make_error(ERR_BAD_MODE);
                  phase_in = PH_HALTED;
               end else begin
                  mode_in  = b[2:0];
                  phase_in = PH_CYL;
               end
            end
            PH_CYL: begin
               cyl_in   = b;
               phase_in = PH_HEAD;
            end
            PH_HEAD: begin
               flags_in = b;
               phase_in = PH_COUNT;
            end
            PH_COUNT: begin
               count_in = b;
               phase_in = PH_SIZE;
            end
            PH_SIZE: begin
               if (b > SIZE_MAX) begin
                  push     = 1'b1;
                  res      = make_error(ERR_BAD_SIZE);
                  phase_in = PH_HALTED;
               end else begin
                  size_in      = b[2:0];
                  idx_in       = 8'd0;
                  base_zero_in = 1'b0;
                  if (count_ff == 8'd0) do_maps_done = 1'b1;
                  else phase_in = PH_NUMMAP;
               end
            end
            PH_NUMMAP: begin
               base_zero_in = bz_now;
               num_we       = 1'b1;
               idx_in       = idx_next;
               if (idx_next >= count_ff) begin
                  idx_in = 8'd0;
                  if (flags_ff[CYL_MAP_BIT]) phase_in = PH_CYLMAP;
                  else if (flags_ff[HEAD_MAP_BIT]) phase_in = PH_HEADMAP;
                  else do_maps_done = 1'b1;
               end
            end
            PH_CYLMAP: begin
               cyl_we = 1'b1;
               idx_in = idx_next;
               if (idx_next >= count_ff) begin
                  idx_in = 8'd0;
                  if (flags_ff[HEAD_MAP_BIT]) phase_in = PH_HEADMAP;
                  else do_maps_done = 1'b1;
               end
            end
            PH_HEADMAP: begin
               hd_we  = 1'b1;
               idx_in = idx_next;
               if (idx_next >= count_ff) do_maps_done = 1'b1;
            end
            PH_STATUS: begin
               if (b > STATUS_MAX) begin
                  push     = 1'b1;
                  res      = make_error(ERR_BAD_STATUS);
                  phase_in = PH_HALTED;
               end else begin
                  if (b == RAW_MISSING) status_in = STAT_MISSING;
                  else if (b <= RAW_OK_FILL) status_in = STAT_OK;
                  else if (b <= RAW_DELETED_END) status_in = STAT_DELETED;
                  else status_in = STAT_BAD_CRC;
                  push = 1'b1;
                  res  = make_sector(KIND_SECTOR, 8'd0, status_in, cyl_ff, flags_ff,
                                     size_ff, mode_ff, idx_in_range, num_rd_ff,
                                     cyl_rd_ff, hd_rd_ff);
                  if (b == RAW_MISSING) begin
                     idx_in   = idx_next;
                     phase_in = (idx_next >= count_ff) ? PH_MODE : PH_STATUS;
                  end else if (b[0]) begin
                     bcnt_in  = 13'((SECTOR_BASE << size_ff) - 14'd1);
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_FILL;
                  end
               end
            end
            PH_DATA: begin
               push = 1'b1;
               res  = make_sector(KIND_DATA, b, status_ff, cyl_ff, flags_ff, size_ff,
                                  mode_ff, idx_in_range, num_rd_ff, cyl_rd_ff, hd_rd_ff);
               if (bcnt_ff == 13'd0) begin
                  idx_in   = idx_next;
                  phase_in = (idx_next >= count_ff) ? PH_MODE : PH_STATUS;
               end else begin
                  bcnt_in = bcnt_ff - 13'd1;
               end
            end
            PH_FILL: begin
               push     = 1'b1;
               res      = make_sector(KIND_FILL, b, status_ff, cyl_ff, flags_ff, size_ff,
                                      mode_ff, idx_in_range, num_rd_ff, cyl_rd_ff,
                                      hd_rd_ff);
               idx_in   = idx_next;
               phase_in = (idx_next >= count_ff) ? PH_MODE : PH_STATUS;
            end
            PH_HALTED: begin
            end
            default: phase_in = PH_COMMENT;
         endcase

         // end of the maps: record the first track's size code, compare later tracks against it
         if (do_maps_done) begin
            idx_in = 8'd0;
            if (!first_seen_ff) begin
               first_seen_in = 1'b1;
               first_size_in = size_in;
               phase_in      = (count_ff == 8'd0) ? PH_MODE : PH_STATUS;
            end else if (first_size_ff != size_in) begin
               push     = 1'b1;
               res      = make_error(ERR_SIZE_MISMATCH);
               phase_in = PH_HALTED;
            end else begin
               phase_in = (count_ff == 8'd0) ? PH_MODE : PH_STATUS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_COMMENT;
         mode_ff       <= '0;
         cyl_ff        <= '0;
         flags_ff      <= '0;
         count_ff      <= '0;
         size_ff       <= '0;
         first_size_ff <= '0;
         first_seen_ff <= 1'b0;
         idx_ff        <= '0;
         bcnt_ff       <= '0;
         base_zero_ff  <= 1'b0;
         status_ff     <= '0;
      end else begin
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         cyl_ff        <= cyl_in;
         flags_ff      <= flags_in;
         count_ff      <= count_in;
         size_ff       <= size_in;
         first_size_ff <= first_size_in;
         first_seen_ff <= first_seen_in;
         idx_ff        <= idx_in;
         bcnt_ff       <= bcnt_in;
         base_zero_ff  <= base_zero_in;
         status_ff     <= status_in;
      end
   end

   // map memories: write at the current index, read at the next one,
   // with write-through when both addresses match
   assign wr_in_range = idx_in_range;

   always_ff @(posedge clock) begin
      if (num_we && wr_in_range) num_mem[idx_ff[IDX_W-1:0]] <= num_wdata;
      if (cyl_we && wr_in_range) cyl_mem[idx_ff[IDX_W-1:0]] <= b;
      if (hd_we && wr_in_range) hd_mem[idx_ff[IDX_W-1:0]] <= b;
   end

   always_ff @(posedge clock) begin
      if (num_we && (idx_ff == idx_in)) num_rd_ff <= num_wdata;
      else num_rd_ff <= num_mem[idx_in[IDX_W-1:0]];
      if (cyl_we && (idx_ff == idx_in)) cyl_rd_ff <= b;
      else cyl_rd_ff <= cyl_mem[idx_in[IDX_W-1:0]];
      if (hd_we && (idx_ff == idx_in)) hd_rd_ff <= b;
      else hd_rd_ff <= hd_mem[idx_in[IDX_W-1:0]];
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!head_valid_ff || pop) begin
         head_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) head_ff <= skid_ff;
      end else if (!head_valid_ff || pop) begin
         if (push) head_ff <= res;
      end else if (push) begin
         skid_ff <= res;
      end
   end

   assign rsp_if.valid            = head_valid_ff;
   assign rsp_if.kind             = head_ff.kind;
   assign rsp_if.cylinder         = head_ff.cylinder;
   assign rsp_if.head             = head_ff.head;
   assign rsp_if.logical_cylinder = head_ff.logical_cylinder;
   assign rsp_if.logical_head     = head_ff.logical_head;
   assign rsp_if.sector_id        = head_ff.sector_id;
   assign rsp_if.sector_status    = head_ff.sector_status;
   assign rsp_if.size_code        = head_ff.size_code;
   assign rsp_if.rate_kbps        = head_ff.rate_kbps;
   assign rsp_if.is_fm            = head_ff.is_fm;
   assign rsp_if.value            = head_ff.value;
   assign rsp_if.error_code       = head_ff.error_code;

   `IMD_ASSERT_HOLDS(a_halted_silent, phase_ff == PH_HALTED, !push, "result after halt")
   `IMD_ASSERT_HOLDS(a_skid_behind_head, skid_valid_ff, head_valid_ff, "skid without head")
   `IMD_ASSERT_NEXT(a_error_halts, push && (res.kind == KIND_ERROR), phase_ff == PH_HALTED,
                    "error did not halt")
   `IMD_ASSERT_NEXT(a_data_ends, accept && (phase_ff == PH_DATA) && (bcnt_ff == 13'd0),
                    phase_ff != PH_DATA, "data phase overran sector")

endmodule
